### rtl/assert_macros.svh
// Assertion helpers for the list engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds on every clock edge outside reset
`define CHECK_IMPL(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies a second condition on the next edge
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ple_pkg.sv
package ple_pkg;

  localparam int Capacity = 32;
  localparam int IdxW = $clog2(Capacity);
  localparam int LenW = $clog2(Capacity + 1);

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_DELETE  = 3'd1;
  localparam logic [2:0] OP_SEARCH  = 3'd2;
  localparam logic [2:0] OP_COUNT   = 3'd3;
  localparam logic [2:0] OP_DISPLAY = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
    logic [7:0]  position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic [5:0]  index_or_count;
    logic        last;
  } res_t;

endpackage

### rtl/ple_ram.sv
module ple_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write one word, read one registered word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ple_front.sv
module ple_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [2:0]    op,
  input  logic [31:0]   value,
  input  logic [7:0]    position,
  output logic          cmd_valid,
  output ple_pkg::cmd_t cmd,
  input  logic          cmd_take
);

  // two-entry command queue
  ple_pkg::cmd_t q [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    cnt;
  logic          accept;
  logic          valid_op;

  assign full      = (cnt == 2'd2);
  assign accept    = push && !full;
  assign valid_op  = (op <= ple_pkg::OP_DISPLAY);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd_ptr];

  // drop unused op codes, queue the rest
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (accept && valid_op) begin
        q[wr_ptr] <= '{op: op, value: value, position: position};
        wr_ptr    <= !wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, accept && valid_op} - {1'b0, cmd_take};
    end
  end

endmodule

### rtl/ple_back.sv
module ple_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  ple_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          res_valid,
  output ple_pkg::res_t res,
  input  logic          res_take,
  output logic [ple_pkg::LenW-1:0] length
);

  localparam int IW = ple_pkg::IdxW;
  localparam int LW = ple_pkg::LenW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_USE   = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]    state;
  logic [2:0]    state_next;
  ple_pkg::cmd_t cur;
  ple_pkg::cmd_t cur_next;
  logic [LW-1:0] idx;
  logic [LW-1:0] idx_next;
  logic [LW-1:0] at;
  logic [LW-1:0] at_next;
  logic [31:0]   held;
  logic [31:0]   held_next;
  logic          we;
  logic          we_next;
  logic [IW-1:0] waddr;
  logic [IW-1:0] waddr_next;
  logic [31:0]   wdata;
  logic [31:0]   wdata_next;
  logic [IW-1:0] raddr;
  logic [31:0]   rdata;
  logic [LW-1:0] length_next;
  logic          res_valid_next;
  ple_pkg::res_t res_next;
  logic [LW-1:0] pos_ext;
  logic [LW-1:0] pos_m1;
  logic [LW:0]   pos_wide;

  ple_ram #(.Width(32), .Depth(ple_pkg::Capacity)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign pos_wide = (cmd.position > 8'(ple_pkg::Capacity)) ?
                    (LW+1)'(ple_pkg::Capacity) : (LW+1)'(cmd.position);
  assign pos_ext  = (pos_wide > (LW+1)'(length)) ? length : LW'(pos_wide);
  assign pos_m1   = (cmd.position == 8'd0) ? '0 :
                    ((pos_wide - 1'b1 > (LW+1)'(length - 1'b1)) ? length - 1'b1
                     : LW'(pos_wide - 1'b1));

  assign cmd_take = cmd_valid && (state == S_IDLE) && !res_valid;

  // read address: insert walks down from length-1, others walk up
  always_comb begin
    if (cur.op == ple_pkg::OP_INSERT) begin
      raddr = IW'(idx - 1'b1);
    end else if (cur.op == ple_pkg::OP_DELETE) begin
      raddr = IW'(idx + 1'b1);
    end else begin
      raddr = IW'(idx);
    end
  end

  // sequence one command over the list, one entry a step
  always_comb begin
    state_next     = state;
    cur_next       = cur;
    idx_next       = idx;
    at_next        = at;
    held_next      = held;
    we_next        = 1'b0;
    waddr_next     = waddr;
    wdata_next     = wdata;
    length_next    = length;
    res_valid_next = res_valid && !res_take;
    res_next       = res;
    unique case (state)
      S_IDLE: begin
        if (cmd_take) begin
          cur_next   = cmd;
          res_next   = '{status: ple_pkg::ST_OK, data: '0, index_or_count: '0, last: 1'b1};
          state_next = S_READ;
          unique case (cmd.op)
            ple_pkg::OP_INSERT: begin
              if (length == LW'(ple_pkg::Capacity)) begin
                res_next.status = ple_pkg::ST_FULL;
                state_next      = S_OUT;
              end else begin
                idx_next = length;
                at_next  = pos_ext;
              end
            end
            ple_pkg::OP_COUNT: begin
              res_next.index_or_count = 6'(length);
              state_next              = S_OUT;
            end
            default: begin
              if (length == '0) begin
                res_next.status = ple_pkg::ST_EMPTY;
                state_next      = S_OUT;
              end else if (cmd.op == ple_pkg::OP_DELETE) begin
                idx_next = pos_m1 - 1'b1;
                at_next  = pos_m1;
              end else begin
                idx_next = '0;
              end
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        state_next = S_USE;
      end
      S_USE: begin
        state_next = S_READ;
        unique case (cur.op)
          ple_pkg::OP_INSERT: begin
            we_next = 1'b1;
            if (idx == at) begin
              waddr_next  = IW'(at);
              wdata_next  = cur.value;
              length_next = length + 1'b1;
              state_next  = S_WRITE;
            end else begin
              waddr_next = IW'(idx);
              wdata_next = rdata;
              idx_next   = idx - 1'b1;
            end
          end
          ple_pkg::OP_DELETE: begin
            if (idx == at - 1'b1) begin
              held_next = rdata;
              idx_next  = at;
              if (at == length - 1'b1) begin
                length_next   = length - 1'b1;
                res_next.data = rdata;
                state_next    = S_OUT;
              end
            end else begin
              we_next    = 1'b1;
              waddr_next = IW'(idx);
              wdata_next = rdata;
              idx_next   = idx + 1'b1;
              if (idx + 1'b1 == length - 1'b1) begin
                length_next   = length - 1'b1;
                res_next.data = held;
                state_next    = S_WRITE;
              end
            end
          end
          ple_pkg::OP_SEARCH: begin
            if (rdata == cur.value) begin
              res_next.index_or_count = 6'(idx + 1'b1);
              state_next              = S_OUT;
            end else if (idx + 1'b1 == length) begin
              res_next.status = ple_pkg::ST_NOTFOUND;
              state_next      = S_OUT;
            end else begin
              idx_next = idx + 1'b1;
            end
          end
          default: begin
            if (!res_valid || res_take) begin
              res_valid_next = 1'b1;
              res_next.data  = rdata;
              res_next.last  = (idx + 1'b1 == length);
              if (idx + 1'b1 == length) begin
                state_next = S_IDLE;
              end else begin
                idx_next = idx + 1'b1;
              end
            end else begin
              state_next = S_USE;
            end
          end
        endcase
      end
      S_WRITE: begin
        state_next = S_OUT;
      end
      default: begin
        if (!res_valid || res_take) begin
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
    endcase
  end

  // advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      res_valid <= 1'b0;
      we        <= 1'b0;
    end else begin
      state     <= state_next;
      length    <= length_next;
      res_valid <= res_valid_next;
      we        <= we_next;
    end
  end

  // advance datapath registers
  always_ff @(posedge clk) begin
    cur   <= cur_next;
    idx   <= idx_next;
    at    <= at_next;
    held  <= held_next;
    waddr <= waddr_next;
    wdata <= wdata_next;
    res   <= res_next;
  end

endmodule

### rtl/positional_list_engine.sv
// Count, insert into a full list and empty-list cases go straight from idle to the output state;
// insert, delete and search walk the entry RAM with a read, wait and use step per entry
// visited, over a list of at most 32 entries.
// Display: one word per entry visited, each sent once the word before it has been popped.
// Throughput: one command in the back end, taken once its last word is popped; two-command queue.
// Reset (rst, synchronous): list length zero, queues empty; entries not cleared.
`include "assert_macros.svh"

module positional_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op,
  input  logic [31:0] value,
  input  logic [7:0]  position,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [31:0] data,
  output logic [5:0]  index_or_count,
  output logic        last
);

  logic          cmd_valid;
  ple_pkg::cmd_t cmd;
  logic          cmd_take;
  logic          res_valid;
  ple_pkg::res_t res;
  logic [ple_pkg::LenW-1:0] length;

  ple_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op), .value(value),
    .position(position), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
  );

  ple_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
    .res_valid(res_valid), .res(res), .res_take(pop), .length(length)
  );

  // expose the result word
  assign empty          = !res_valid;
  assign status         = res.status;
  assign data           = res.data;
  assign index_or_count = res.index_or_count;
  assign last           = res.last;

  `CHECK_IMPL(a_len_cap, clk, rst, length <= ple_pkg::LenW'(ple_pkg::Capacity),
    "list length beyond capacity")
  `CHECK_NEXT(a_res_hold, clk, rst, res_valid && !pop, $stable(res) && res_valid,
    "waiting result word changed")
  `CHECK_IMPL(a_take_valid, clk, rst, !cmd_take || cmd_valid,
    "command taken from empty queue")

endmodule
